### sv/bssf_pkg.sv
`default_nettype none

package bssf_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned ACC_W    = 22;
	localparam int unsigned SHIFT_W  = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [SAMPLE_W-1:0] LOW_BITS_CLEAR = 16'hFFF0;
	localparam logic [SHIFT_W-1:0]  MAX_SHIFT      = 3'd6;

	typedef enum logic [1:0] {
		MODE_PASS     = 2'd0,
		MODE_TRUNCATE = 2'd1,
		MODE_AVERAGE  = 2'd2,
		MODE_REACTIVE = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_MODE    = 2'd0,
		REG_PLAIN_SHIFT    = 2'd1,
		REG_REACTIVE_SHIFT = 2'd2,
		REG_JUMP_THRESHOLD = 2'd3
	} reg_idx_t;

	localparam mode_t                RST_FILTER_MODE    = MODE_PASS;
	localparam logic [SHIFT_W-1:0]   RST_PLAIN_SHIFT    = 3'd4;
	localparam logic [SHIFT_W-1:0]   RST_REACTIVE_SHIFT = 3'd3;
	localparam logic [SAMPLE_W-1:0]  RST_JUMP_THRESHOLD = 16'd32;

	typedef struct packed {
		mode_t                 filter_mode;
		logic [SHIFT_W-1:0]    plain_average_shift;
		logic [SHIFT_W-1:0]    reactive_average_shift;
		logic [SAMPLE_W-1:0]   jump_threshold;
	} cfg_t;

endpackage

`default_nettype wire

### sv/bssf_if.sv
`default_nettype none

interface bssf_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface bssf_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] filtered;

	modport source (output valid, output filtered, input ready);
	modport sink   (input valid, input filtered, output ready);
endinterface

interface bssf_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/battery_sample_smoothing_filter.sv
// A request accepted into the stage 1 input register moves on to the stage 2 result register once that is free.
// Throughput: one request per cycle while the output is not stalled; the accumulator is read
//   and rewritten in the same cycle, so there is no stall between dependent requests.
// Output stall back-pressures the input stage only when both stages are full.
// Reset (arst_n low, asynchronous): pipeline empty, accumulator zero, mode 0,
//   shifts 4 and 3, jump threshold 32.
`default_nettype none

module battery_sample_smoothing_filter (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bssf_in_if.sink    samples,
	bssf_out_if.source results,
	bssf_cfg_if.sink   cfg
);
	import bssf_pkg::*;

	// configuration registers
	cfg_t             cfg_q;

	// stage 1: input register
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// stage 2: result register
	logic                valid_s2;
	logic [SAMPLE_W-1:0] filtered_s2;

	// running average, scaled by 2^shift
	logic [ACC_W-1:0]    acc_q;

	logic                advance;
	logic                fire;
	logic [ACC_W-1:0]    acc_next;
	logic                acc_we;
	logic [SAMPLE_W-1:0] filtered_next;

	// Result register frees up when empty or being taken this cycle.
	assign advance = !valid_s2 || results.ready;
	// A request in stage 1 is processed whenever the result register can take it.
	assign fire    = valid_s1 && advance;

	assign samples.ready    = !valid_s1 || advance;
	assign results.valid    = valid_s2;
	assign results.filtered = filtered_s2;
	assign cfg.ready        = 1'b1;

	// Configuration writes; the user must issue them only while the pipeline is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode            <= RST_FILTER_MODE;
			cfg_q.plain_average_shift    <= RST_PLAIN_SHIFT;
			cfg_q.reactive_average_shift <= RST_REACTIVE_SHIFT;
			cfg_q.jump_threshold         <= RST_JUMP_THRESHOLD;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_FILTER_MODE:    cfg_q.filter_mode <= mode_t'(cfg.data[1:0]);
				REG_PLAIN_SHIFT:    cfg_q.plain_average_shift <= cfg.data[SHIFT_W-1:0];
				REG_REACTIVE_SHIFT: cfg_q.reactive_average_shift <= cfg.data[SHIFT_W-1:0];
				REG_JUMP_THRESHOLD: cfg_q.jump_threshold <= cfg.data;
				default: ;
			endcase
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	// Stage 1 payload, no reset needed
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1 <= samples.sample;
		end
	end

	// Single-pass update: seed / jump / average step, saturated output, or pass / truncate
	bssf_avg_unit u_avg (
		.cfg      (cfg_q),
		.acc      (acc_q),
		.sample   (sample_s1),
		.acc_next (acc_next),
		.acc_we   (acc_we),
		.filtered (filtered_next)
	);

	// Accumulator: only averaging modes touch it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (fire && acc_we) begin
			acc_q <= acc_next;
		end
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (fire) begin
			filtered_s2 <= filtered_next;
		end
	end

	// Pass and truncate modes never disturb the average
	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cfg_q.filter_mode == MODE_PASS || cfg_q.filter_mode == MODE_TRUNCATE)
		|=> $stable(acc_q))
		else $error("accumulator changed outside averaging modes");

	// Stage 1 holds its request while stage 2 is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(sample_s1))
		else $error("stage 1 request lost under stall");

	// Pass mode delivers the sample unchanged in the following cycle
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cfg_q.filter_mode == MODE_PASS
		|=> valid_s2 && filtered_s2 == $past(sample_s1))
		else $error("pass mode result mismatch");

	// Averaging from an empty accumulator seeds with the scaled sample
	a_seed: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cfg_q.filter_mode == MODE_AVERAGE && acc_q == '0
		&& cfg_q.plain_average_shift == 3'd0
		|=> acc_q == ACC_W'($past(sample_s1)))
		else $error("seed value wrong");

endmodule

`default_nettype wire

### sv/bssf_avg_unit.sv
`default_nettype none

module bssf_avg_unit (
	input  wire bssf_pkg::cfg_t               cfg,
	input  wire logic [bssf_pkg::ACC_W-1:0]    acc,
	input  wire logic [bssf_pkg::SAMPLE_W-1:0] sample,
	output logic      [bssf_pkg::ACC_W-1:0]    acc_next,
	output logic                               acc_we,
	output logic      [bssf_pkg::SAMPLE_W-1:0] filtered
);
	import bssf_pkg::*;

	logic [SHIFT_W-1:0]  shift_raw;
	logic [SHIFT_W-1:0]  shift;
	logic [ACC_W-1:0]    x_ext;
	logic [ACC_W-1:0]    avg;
	logic [ACC_W-1:0]    step;
	logic [ACC_W-1:0]    seed;
	logic [ACC_W-1:0]    diff;
	logic                jump;
	logic                reload;
	logic [ACC_W-1:0]    out_avg;
	logic [SAMPLE_W-1:0] avg_sat;

	always_comb begin
		shift_raw = (cfg.filter_mode == MODE_REACTIVE) ? cfg.reactive_average_shift
		                                               : cfg.plain_average_shift;
		// a shift of seven acts as six so the seed always fits
		shift  = (shift_raw > MAX_SHIFT) ? MAX_SHIFT : shift_raw;
		x_ext  = ACC_W'(sample);
		avg    = acc >> shift;
		step   = acc - avg + x_ext;
		seed   = x_ext << shift;
		diff   = (avg > x_ext) ? (avg - x_ext) : (x_ext - avg);
		jump   = diff > ACC_W'(cfg.jump_threshold);
		reload = (cfg.filter_mode == MODE_REACTIVE) ? jump : (acc == '0);
		acc_next = reload ? seed : step;
		out_avg  = acc_next >> shift;
		// lowered shift can leave an average above full scale
		avg_sat  = (|out_avg[ACC_W-1:SAMPLE_W]) ? '1 : out_avg[SAMPLE_W-1:0];

		case (cfg.filter_mode)
			MODE_PASS: begin
				acc_we   = 1'b0;
				filtered = sample;
			end
			MODE_TRUNCATE: begin
				acc_we   = 1'b0;
				filtered = sample & LOW_BITS_CLEAR;
			end
			MODE_AVERAGE, MODE_REACTIVE: begin
				acc_we   = 1'b1;
				filtered = avg_sat;
			end
			default: begin
				acc_we   = 1'b0;
				filtered = sample;
			end
		endcase
	end

endmodule

`default_nettype wire

### tb/battery_sample_smoothing_filter_tb.sv
`default_nettype none

module battery_sample_smoothing_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bssf_pkg::*;

	// Run sizing. The block has two stages, so a handful of cycles is enough
	// for it to settle once the last result is out.
	localparam int unsigned RANDOM_ITEMS = 650;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned CYCLE_LIMIT  = 300000;

	logic clk;
	logic arst_n;

	bssf_in_if  samples_if ();
	bssf_out_if results_if ();
	bssf_cfg_if cfg_if ();

	battery_sample_smoothing_filter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	// Shadow copy of the block: register file and the shared accumulator.
	cfg_t                shadow_cfg;
	logic [ACC_W-1:0]    shadow_acc;

	// Samples waiting to be offered, and filtered values still owed by the block.
	logic [SAMPLE_W-1:0] pending_samples[$];
	logic [SAMPLE_W-1:0] expected_filtered[$];

	int unsigned queued_samples;
	int unsigned accepted_samples;
	int unsigned reg_writes;
	int unsigned mode_hits[4];
	int unsigned saturated_outputs;
	int unsigned reactive_reloads;
	int unsigned fail_count;
	int unsigned cycle_count;

	// Back-pressure knobs, percent of cycles spent idle.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	// Long output hold-off: the sequence bumps hold_requests, the receiver
	// serves it and counts the stretch down on its own.
	int unsigned hold_requests;
	int unsigned hold_served;
	int unsigned hold_left;

	// Random walk state for the sample generator.
	int walk_level;
	int walk_step;

	// ------------------------------------------------------------------
	// Clock, 20 ns period.
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a stuck handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor: one filtered value per accepted sample, updates the shadow
	// accumulator as the block does.
	// ------------------------------------------------------------------
	function automatic logic [SAMPLE_W-1:0] smooth_sample(input logic [SAMPLE_W-1:0] x);
		logic [SHIFT_W-1:0] s;
		logic [ACC_W-1:0]   avg;
		logic [ACC_W-1:0]   gap;
		logic               reload;
		s      = '0;
		reload = 1'b0;
		case (shadow_cfg.filter_mode)
			MODE_PASS:     return x;
			MODE_TRUNCATE: return x & LOW_BITS_CLEAR;
			MODE_AVERAGE: begin
				// shift of seven behaves as six
				s = (shadow_cfg.plain_average_shift > MAX_SHIFT) ?
					MAX_SHIFT : shadow_cfg.plain_average_shift;
				// empty accumulator is seeded rather than averaged
				reload = (shadow_acc == '0);
			end
			default: begin
				s = (shadow_cfg.reactive_average_shift > MAX_SHIFT) ?
					MAX_SHIFT : shadow_cfg.reactive_average_shift;
				avg = shadow_acc >> s;
				gap = (avg > ACC_W'(x)) ? avg - ACC_W'(x) : ACC_W'(x) - avg;
				// jump beyond the threshold reloads the average
				reload = (gap > ACC_W'(shadow_cfg.jump_threshold));
				if (reload) begin
					reactive_reloads++;
				end
			end
		endcase
		if (reload) begin
			shadow_acc = ACC_W'(x) << s;
		end else begin
			shadow_acc = shadow_acc - (shadow_acc >> s) + ACC_W'(x);
		end
		avg = shadow_acc >> s;
		// average can outgrow 16 bits after the shift is lowered
		if (avg > ACC_W'(16'hFFFF)) begin
			saturated_outputs++;
			return '1;
		end
		return avg[SAMPLE_W-1:0];
	endfunction

	// Register write as the block sees it: only the low bits of each field count.
	function automatic void shadow_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_FILTER_MODE:    shadow_cfg.filter_mode            = mode_t'(d[1:0]);
			REG_PLAIN_SHIFT:    shadow_cfg.plain_average_shift    = d[SHIFT_W-1:0];
			REG_REACTIVE_SHIFT: shadow_cfg.reactive_average_shift = d[SHIFT_W-1:0];
			default:            shadow_cfg.jump_threshold         = d;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Sample driver: offers the next pending sample, holds a request until it
	// is taken, idles at random between requests.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			samples_if.valid  <= 1'b0;
			samples_if.sample <= '0;
		end else if (!samples_if.valid || samples_if.ready) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				samples_if.valid  <= 1'b1;
				samples_if.sample <= pending_samples.pop_front();
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus the long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
			results_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: tracks register writes and accepted samples into the shadow
	// model, checks every result against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic [SAMPLE_W-1:0] want;
		if (arst_n) begin
			if (results_if.valid && results_if.ready) begin
				if (expected_filtered.size() == 0) begin
					$error("filtered: unexpected result 0x%04h", results_if.filtered);
					fail_count++;
				end else begin
					want = expected_filtered.pop_front();
					if (results_if.filtered !== want) begin
						$error("filtered mismatch: expected 0x%04h, actual 0x%04h",
							want, results_if.filtered);
						fail_count++;
					end
				end
			end
			if (cfg_if.valid && cfg_if.ready) begin
				shadow_write(reg_idx_t'(cfg_if.index), cfg_if.data);
				reg_writes++;
			end
			if (samples_if.valid && samples_if.ready) begin
				mode_hits[shadow_cfg.filter_mode]++;
				expected_filtered.push_back(smooth_sample(samples_if.sample));
				accepted_samples++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence helpers.
	// ------------------------------------------------------------------
	function automatic void queue_sample(input logic [SAMPLE_W-1:0] x);
		pending_samples.push_back(x);
		queued_samples++;
	endfunction

	// Mostly a slow walk so the reactive mode spends time averaging, with
	// full-range values and the rails thrown in.
	function automatic logic [SAMPLE_W-1:0] next_sample();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			walk_level += int'($urandom_range(2 * walk_step)) - walk_step;
			if (walk_level < 0) begin
				walk_level = 0;
			end
			if (walk_level > 65535) begin
				walk_level = 65535;
			end
		end else if (pick < 85) begin
			walk_level = int'($urandom_range(65535));
		end else begin
			walk_level = $urandom_range(1) ? 65535 : 0;
		end
		return walk_level[SAMPLE_W-1:0];
	endfunction

	// One register write request; valid is left high so back-to-back writes
	// need no gap. Called at a rising edge.
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= d;
		do @(posedge clk); while (!cfg_if.ready);
	endtask

	// Writes all four registers with junk in the unused upper bits, then
	// returns at a falling edge.
	task automatic apply_settings(input mode_t mode, input logic [SHIFT_W-1:0] pshift,
			input logic [SHIFT_W-1:0] rshift, input logic [SAMPLE_W-1:0] thr);
		logic [CFG_DATA_W-1:0] d;
		@(posedge clk);
		d = CFG_DATA_W'($urandom);
		d[1:0] = mode;
		write_reg(REG_FILTER_MODE, d);
		d = CFG_DATA_W'($urandom);
		d[SHIFT_W-1:0] = pshift;
		write_reg(REG_PLAIN_SHIFT, d);
		d = CFG_DATA_W'($urandom);
		d[SHIFT_W-1:0] = rshift;
		write_reg(REG_REACTIVE_SHIFT, d);
		write_reg(REG_JUMP_THRESHOLD, thr);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Idle means every sample taken and every result returned.
	task automatic wait_drained();
		while (accepted_samples != queued_samples || expected_filtered.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned n_items, input bit with_hold);
		int unsigned done;
		int unsigned chunk;
		int unsigned pick;
		mode_t       mode;
		logic [SAMPLE_W-1:0] thr;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		done = 0;
		while (done < n_items) begin
			// averaging modes get most of the time
			pick = $urandom_range(9);
			mode = (pick == 0) ? MODE_PASS : (pick == 1) ? MODE_TRUNCATE :
				(pick < 6) ? MODE_AVERAGE : MODE_REACTIVE;
			case ($urandom_range(3))
				0:       thr = SAMPLE_W'($urandom_range(64));
				1:       thr = SAMPLE_W'($urandom_range(1024));
				2:       thr = SAMPLE_W'($urandom);
				default: thr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			endcase
			apply_settings(mode, SHIFT_W'($urandom_range(7)), SHIFT_W'($urandom_range(7)), thr);
			walk_step = int'($urandom_range(80));
			chunk = $urandom_range(40, 10);
			if (with_hold && done == 0) begin
				// receiver holds off while the sender keeps requesting
				hold_requests++;
				chunk = 40;
			end
			repeat (chunk) queue_sample(next_sample());
			done += chunk;
			wait_drained();
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		samples_if.valid  = 1'b0;
		samples_if.sample = '0;
		results_if.ready  = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = REG_FILTER_MODE;
		cfg_if.data       = '0;
		send_idle_pct     = 0;
		recv_idle_pct     = 0;
		hold_requests     = 0;
		hold_served       = 0;
		hold_left         = 0;
		walk_level        = 32768;
		walk_step         = 16;
		queued_samples    = 0;
		accepted_samples  = 0;
		reg_writes        = 0;
		saturated_outputs = 0;
		reactive_reloads  = 0;
		fail_count        = 0;
		cycle_count       = 0;
		foreach (mode_hits[i]) mode_hits[i] = 0;

		shadow_cfg.filter_mode            = RST_FILTER_MODE;
		shadow_cfg.plain_average_shift    = RST_PLAIN_SHIFT;
		shadow_cfg.reactive_average_shift = RST_REACTIVE_SHIFT;
		shadow_cfg.jump_threshold         = RST_JUMP_THRESHOLD;
		shadow_acc                        = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset settings pass straight through.
		queue_sample(16'h0000); queue_sample(16'hFFFF);
		queue_sample(16'hA5A5); queue_sample(16'h5A5A);
		wait_drained();

		// Low nibble cleared.
		apply_settings(MODE_TRUNCATE, RST_PLAIN_SHIFT, RST_REACTIVE_SHIFT, RST_JUMP_THRESHOLD);
		queue_sample(16'hFFFF); queue_sample(16'h000F); queue_sample(16'h8010);
		wait_drained();

		// Plain average: zero keeps reseeding, then a seed and steps.
		apply_settings(MODE_AVERAGE, RST_PLAIN_SHIFT, RST_REACTIVE_SHIFT, RST_JUMP_THRESHOLD);
		queue_sample(16'h0000); queue_sample(16'h0000); queue_sample(16'h1000);
		queue_sample(16'h1010); queue_sample(16'hFFFF);
		wait_drained();

		// Reactive reload at the deepest shift fills the accumulator...
		apply_settings(MODE_REACTIVE, 3'd4, MAX_SHIFT, 16'h0000);
		queue_sample(16'hFFFF);
		wait_drained();

		// ...then the plain average with a lower shift must saturate.
		apply_settings(MODE_AVERAGE, 3'd3, MAX_SHIFT, 16'h0000);
		queue_sample(16'hFFFF); queue_sample(16'h0000);
		wait_drained();

		// Shift of seven, then shift of zero.
		apply_settings(MODE_AVERAGE, 3'd7, MAX_SHIFT, 16'h0000);
		queue_sample(16'h1234); queue_sample(16'h1240);
		wait_drained();
		apply_settings(MODE_AVERAGE, 3'd0, MAX_SHIFT, 16'h0000);
		queue_sample(16'h0100); queue_sample(16'h0200);
		wait_drained();

		// Reactive with carried-over accumulator: small step, jump, small step.
		apply_settings(MODE_REACTIVE, 3'd0, RST_REACTIVE_SHIFT, RST_JUMP_THRESHOLD);
		queue_sample(16'h0050); queue_sample(16'h2000); queue_sample(16'h2010);
		wait_drained();

		// Threshold extremes.
		apply_settings(MODE_REACTIVE, 3'd1, 3'd1, 16'hFFFF);
		queue_sample(16'h0000); queue_sample(16'hFFFF);
		wait_drained();
		apply_settings(MODE_REACTIVE, 3'd1, 3'd5, 16'h0000);
		queue_sample(16'h1111); queue_sample(16'h1111);
		wait_drained();

		// Random: fast sender / busy receiver, then the reverse, then flat out
		// with one long output hold-off.
		random_phase(10, 57, RANDOM_ITEMS / 3, 1'b0);
		random_phase(57, 10, RANDOM_ITEMS / 3, 1'b0);
		random_phase(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 1'b1);

		wait_drained();
		if (expected_filtered.size() != 0) begin
			$error("filtered: %0d results never arrived", expected_filtered.size());
			fail_count++;
		end

		$display("Covered %0d samples: pass %0d, truncate %0d, average %0d, reactive %0d.",
			accepted_samples, mode_hits[MODE_PASS], mode_hits[MODE_TRUNCATE],
			mode_hits[MODE_AVERAGE], mode_hits[MODE_REACTIVE]);
		$display("%0d register writes, %0d reactive reloads, %0d saturated outputs.",
			reg_writes, reactive_reloads, saturated_outputs);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

### files.f
sv/bssf_pkg.sv
sv/bssf_if.sv
sv/bssf_avg_unit.sv
sv/battery_sample_smoothing_filter.sv
tb/battery_sample_smoothing_filter_tb.sv
